@@ rtl/core/ffba_pkg.sv @@
// ----------------------------------------------------------------------------
// ffba_pkg
// Types, constants and helpers shared by the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

	localparam int MAX_BLOCKS  = 64;
	localparam int IDX_W       = $clog2(MAX_BLOCKS);
	localparam int HEAD_W      = IDX_W + 1;
	localparam int ALIGN_BYTES = 32;
	localparam int ADDR_W      = 24;
	localparam int SIZE_W      = 25;
	localparam int PADDR_W     = 3;

	localparam logic [HEAD_W-1:0] HEAD_EMPTY = HEAD_W'(MAX_BLOCKS);

	localparam logic       REQ_ALLOC = 1'b0;
	localparam logic       REQ_FREE  = 1'b1;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_NO_SPACE   = 3'd1;
	localparam logic [2:0] ST_BAD_SIZE   = 3'd2;
	localparam logic [2:0] ST_TABLE_FULL = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND  = 3'd4;

	localparam logic [PADDR_W-1:0] REG_BASE_ADDRESS = PADDR_W'(0);
	localparam logic [PADDR_W-1:0] REG_POOL_SIZE    = PADDR_W'(4);

	typedef struct packed {
		logic              req_type;
		logic [SIZE_W-1:0] request_bytes;
		logic [ADDR_W-1:0] free_address;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] block_address;
		logic [2:0]        status;
		logic [SIZE_W-1:0] bytes_in_use;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [SIZE_W-1:0] size;
		logic [IDX_W-1:0]  next;
	} entry_t;

	// Rounds a size up to the block alignment; one bit wider than the size.
	function automatic logic [SIZE_W:0] round_up(input logic [SIZE_W-1:0] n);
		logic [SIZE_W:0] sum;
		sum = (SIZE_W+1)'(n) + (SIZE_W+1)'(ALIGN_BYTES - 1);
		return sum & ~((SIZE_W+1)'(ALIGN_BYTES - 1));
	endfunction

endpackage

@@ rtl/core/first_fit_block_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit
// Address-ordered first-fit allocator over a linked table of block descriptors.
// ----------------------------------------------------------------------------
// A request transfer happens at a clock edge where start is high and busy is
// low; req carries the request type, the size to allocate or the address to
// free. Busy stays high until the request is answered. Each answer is shown
// on rsp for exactly one cycle with done high; the receiver cannot stall it.
// The descriptors live in one 64-entry memory with a registered read port.
// The walk reads one descriptor per cycle, at most 64 in all, so the memory
// read port sets the rate. An allocate walks to a fitting gap or the last
// entry, then writes the new descriptor and relinks the one before it, or
// answers no space. A free walks to the matching address and unlinks it. A
// bad size, a full table and an allocate or free on an empty list are
// answered without a walk. base_address and pool_size are to be written
// through the APB port only while the block is idle; the block does not
// enforce this. Reset empties the list, clears all valid bits and the byte
// total, and restores the register reset values; no clearing pass is needed.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  ffba_pkg::req_t                req,
	output logic                          done,
	output ffba_pkg::rsp_t                rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ffba_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import ffba_pkg::*;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_CHECK   = 3'd1;
	localparam logic [2:0] S_STEP    = 3'd2;
	localparam logic [2:0] S_LAST    = 3'd3;
	localparam logic [2:0] S_WR_NEW  = 3'd4;
	localparam logic [2:0] S_WR_LINK = 3'd5;
	localparam logic [2:0] S_FSTEP   = 3'd6;

	logic [2:0]            state_q;
	req_t                  req_q;
	rsp_t                  rsp_q;
	logic                  done_q;
	logic [ADDR_W-1:0]     base_q;
	logic [SIZE_W-1:0]     pool_q;
	logic [HEAD_W-1:0]     head_q;
	logic [SIZE_W-1:0]     total_q;
	logic [MAX_BLOCKS-1:0] valid_q;
	logic [IDX_W-1:0]      e_q;
	logic [IDX_W-1:0]      cur_q;
	logic [IDX_W-1:0]      rd_idx_q;
	logic [IDX_W-1:0]      prev_q;
	logic [IDX_W-1:0]      new_next_q;
	logic                  prev_none_q;
	logic                  cmp_q;
	entry_t                cur_word_q;
	entry_t                prev_word_q;
	logic [SIZE_W:0]       end_q;
	logic [SIZE_W+1:0]     lim_q;
	logic [SIZE_W:0]       limit_q;

	entry_t                mem [MAX_BLOCKS];
	entry_t                rd_data_q;
	logic                  mem_we;
	logic [IDX_W-1:0]      mem_waddr;
	entry_t                mem_wdata;
	logic                  mem_re;
	logic [IDX_W-1:0]      mem_raddr;

	logic                  cfg_wr;
	logic [IDX_W-1:0]      free_idx;
	logic                  has_free;
	logic                  head_empty;
	logic                  bad_size;
	logic                  fit;
	logic                  is_last;
	logic                  match;
	logic                  append_ok;
	logic [SIZE_W:0]       step_end;
	logic [SIZE_W+1:0]     step_lim;
	logic [SIZE_W:0]       round_n;
	logic [SIZE_W:0]       round_hit;
	logic [IDX_W-1:0]      link_next;

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign rsp    = rsp_q;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_POOL_SIZE[2]) ? 32'(pool_q) : 32'(base_q);
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		free_idx = '0;
		has_free = 1'b0;
		for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IDX_W'(i);
				has_free = 1'b1;
			end
		end
	end

	assign head_empty = (head_q == HEAD_EMPTY);
	assign bad_size   = (req_q.request_bytes == '0);
	assign round_n    = round_up(req_q.request_bytes);
	assign round_hit  = round_up(rd_data_q.size);
	assign step_end   = (SIZE_W+1)'(rd_data_q.start) + round_hit;
	assign step_lim   = (SIZE_W+2)'(step_end) + (SIZE_W+2)'(req_q.request_bytes);
	assign fit        = cmp_q && ((SIZE_W+2)'(rd_data_q.start) >= lim_q);
	assign is_last    = (rd_data_q.next == rd_idx_q);
	assign match      = (rd_data_q.start == req_q.free_address);
	assign append_ok  = (lim_q <= (SIZE_W+2)'(limit_q)) &&
	                    (end_q <= (SIZE_W+1)'({ADDR_W{1'b1}}));
	assign link_next  = is_last ? prev_q : rd_data_q.next;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		case (state_q)
			S_CHECK: begin
				if (req_q.req_type == REQ_ALLOC) begin
					if (!bad_size && has_free) begin
						if (head_empty) begin
							mem_we    = 1'b1;
							mem_waddr = free_idx;
							mem_wdata = '{start: base_q, size: req_q.request_bytes,
							              next: free_idx};
						end else begin
							mem_re    = 1'b1;
							mem_raddr = head_q[IDX_W-1:0];
						end
					end
				end else if (!head_empty) begin
					mem_re    = 1'b1;
					mem_raddr = head_q[IDX_W-1:0];
				end
			end
			S_STEP: begin
				if (!fit && !is_last) begin
					mem_re    = 1'b1;
					mem_raddr = rd_data_q.next;
				end
			end
			S_WR_NEW: begin
				mem_we    = 1'b1;
				mem_waddr = e_q;
				mem_wdata = '{start: end_q[ADDR_W-1:0], size: req_q.request_bytes,
				              next: new_next_q};
			end
			S_WR_LINK: begin
				mem_we    = 1'b1;
				mem_waddr = cur_q;
				mem_wdata = '{start: cur_word_q.start, size: cur_word_q.size, next: e_q};
			end
			S_FSTEP: begin
				if (match) begin
					if (!prev_none_q) begin
						mem_we    = 1'b1;
						mem_waddr = prev_q;
						mem_wdata = '{start: prev_word_q.start, size: prev_word_q.size,
						              next: link_next};
					end
				end else if (!is_last) begin
					mem_re    = 1'b1;
					mem_raddr = rd_data_q.next;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			pool_q <= SIZE_W'(1 << ADDR_W);
		end else if (cfg_wr) begin
			if (paddr[2] == REG_BASE_ADDRESS[2]) begin
				base_q <= pwdata[ADDR_W-1:0];
			end else begin
				pool_q <= pwdata[SIZE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CHECK) begin
			limit_q <= (SIZE_W+1)'(base_q) + (SIZE_W+1)'(pool_q);
			e_q     <= free_idx;
		end
		if (state_q == S_IDLE && start) begin
			req_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			done_q      <= 1'b0;
			rsp_q       <= '0;
			head_q      <= HEAD_EMPTY;
			total_q     <= '0;
			valid_q     <= '0;
			cur_q       <= '0;
			rd_idx_q    <= '0;
			prev_q      <= '0;
			new_next_q  <= '0;
			prev_none_q <= 1'b1;
			cmp_q       <= 1'b0;
			cur_word_q  <= '0;
			prev_word_q <= '0;
			end_q       <= '0;
			lim_q       <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (req_q.req_type == REQ_ALLOC) begin
						if (bad_size) begin
							rsp_q   <= '{block_address: '0, status: ST_BAD_SIZE,
							            bytes_in_use: total_q};
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else if (!has_free) begin
							rsp_q   <= '{block_address: '0, status: ST_TABLE_FULL,
							            bytes_in_use: total_q};
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else if (head_empty) begin
							head_q            <= HEAD_W'(free_idx);
							valid_q[free_idx] <= 1'b1;
							total_q           <= total_q + round_n[SIZE_W-1:0];
							rsp_q   <= '{block_address: base_q, status: ST_OK,
							            bytes_in_use: total_q + round_n[SIZE_W-1:0]};
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							rd_idx_q <= head_q[IDX_W-1:0];
							cmp_q    <= 1'b0;
							state_q  <= S_STEP;
						end
					end else begin
						if (head_empty) begin
							rsp_q   <= '{block_address: '0, status: ST_NOT_FOUND,
							            bytes_in_use: total_q};
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							rd_idx_q    <= head_q[IDX_W-1:0];
							prev_none_q <= 1'b1;
							state_q     <= S_FSTEP;
						end
					end
				end
				S_STEP: begin
					if (fit) begin
						new_next_q <= rd_idx_q;
						state_q    <= S_WR_NEW;
					end else begin
						cur_q      <= rd_idx_q;
						cur_word_q <= rd_data_q;
						end_q      <= step_end;
						lim_q      <= step_lim;
						if (is_last) begin
							state_q <= S_LAST;
						end else begin
							rd_idx_q <= rd_data_q.next;
							cmp_q    <= 1'b1;
						end
					end
				end
				S_LAST: begin
					if (append_ok) begin
						new_next_q <= e_q;
						state_q    <= S_WR_NEW;
					end else begin
						rsp_q   <= '{block_address: '0, status: ST_NO_SPACE,
						            bytes_in_use: total_q};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_WR_NEW: begin
					valid_q[e_q] <= 1'b1;
					total_q      <= total_q + round_n[SIZE_W-1:0];
					state_q      <= S_WR_LINK;
				end
				S_WR_LINK: begin
					rsp_q   <= '{block_address: end_q[ADDR_W-1:0], status: ST_OK,
					            bytes_in_use: total_q};
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_FSTEP: begin
					if (match) begin
						if (prev_none_q) begin
							head_q <= is_last ? HEAD_EMPTY : HEAD_W'(rd_data_q.next);
						end
						valid_q[rd_idx_q] <= 1'b0;
						total_q           <= total_q - round_hit[SIZE_W-1:0];
						rsp_q   <= '{block_address: '0, status: ST_OK,
						            bytes_in_use: total_q - round_hit[SIZE_W-1:0]};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (is_last) begin
						rsp_q   <= '{block_address: '0, status: ST_NOT_FOUND,
						            bytes_in_use: total_q};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						prev_q      <= rd_idx_q;
						prev_word_q <= rd_data_q;
						prev_none_q <= 1'b0;
						rd_idx_q    <= rd_data_q.next;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a request in progress");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	a_empty_no_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == HEAD_EMPTY) |-> (valid_q == '0))
		else $error("empty list with live descriptors");

	a_empty_no_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == HEAD_EMPTY) |-> (total_q == '0))
		else $error("empty list with bytes in use");

endmodule
